// ===== rtl/tcp_receive_reassembly_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// tcp receive reassembly tracker assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef TCP_RECEIVE_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH
`define TCP_RECEIVE_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCPRR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcprr assertion failed");

// next-cycle implication
`define TCPRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcprr assertion failed");

`endif

// ===== rtl/tcprr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcprr_pkg
// types and constants of the tcp receive reassembly tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcprr_pkg;

    localparam int MAX_GAPS = 16;

    localparam logic [16:0] BUF_LEN_RESET = 17'd10240;

    localparam logic CFG_BUFFER_LENGTH    = 1'b0;
    localparam logic CFG_INITIAL_SEQUENCE = 1'b1;

    localparam logic RESULT_ACK = 1'b0;
    localparam logic RESULT_FIN = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_FINISH
    } t_state;

    typedef enum logic {
        PHASE_MATCH,
        PHASE_INSERT
    } t_phase;

    // token handed from cell to cell
    typedef struct packed {
        logic        active;
        t_phase      phase;
        logic        found;
        logic        split_pend;
        logic [31:0] split_end;
        logic        open_pend;
        logic        any_gap;
        logic [31:0] min_start;
    } t_carry;

    // segment values seen by every cell
    typedef struct packed {
        logic signed [33:0] rel;
        logic signed [33:0] seg_end;
        logic               size_nz;
        logic [31:0]        highest;
    } t_bcast;

endpackage

`default_nettype wire

// ===== rtl/tcprr_cell.sv =====
// ----------------------------------------------------------------------------
// tcprr_cell
// one gap entry of the chain, trims, splits or takes a gap as the token passes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcprr_cell
    import tcprr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_bcast i_bcast,
    input  wire t_carry i_carry,
    output t_carry      o_carry
);

    logic        r_valid, n_valid;
    logic [31:0] r_start, n_start;
    logic [31:0] r_end, n_end;
    t_carry      r_carry, n_carry;

    logic signed [33:0] w_s;
    logic signed [33:0] w_e;

    assign w_s = $signed({2'b00, r_start});
    assign w_e = $signed({2'b00, r_end});

    always_comb begin
        n_valid = r_valid;
        n_start = r_start;
        n_end   = r_end;
        n_carry = i_carry;
        if (i_carry.active) begin
            if (i_carry.phase == PHASE_MATCH) begin
                if (i_bcast.size_nz && !i_carry.found && r_valid) begin
                    if (i_bcast.rel == w_s) begin
                        if (i_bcast.seg_end < w_e) begin
                            n_start = i_bcast.seg_end[31:0];
                        end else begin
                            n_valid = 1'b0;
                        end
                        n_carry.found = 1'b1;
                    end else if (i_bcast.rel > w_s && i_bcast.rel < w_e) begin
                        n_end = i_bcast.rel[31:0];
                        if (i_bcast.seg_end < w_e) begin
                            n_carry.split_pend = 1'b1;
                            n_carry.split_end  = r_end;
                        end
                        n_carry.found = 1'b1;
                    end
                end
            end else begin
                if (!r_valid && i_carry.split_pend) begin
                    n_valid            = 1'b1;
                    n_start            = i_bcast.seg_end[31:0];
                    n_end              = i_carry.split_end;
                    n_carry.split_pend = 1'b0;
                end else if (!r_valid && i_carry.open_pend) begin
                    n_valid           = 1'b1;
                    n_start           = i_bcast.highest;
                    n_end             = i_bcast.rel[31:0];
                    n_carry.open_pend = 1'b0;
                end
                if (n_valid && (!n_carry.any_gap || n_start < n_carry.min_start)) begin
                    n_carry.min_start = n_start;
                    n_carry.any_gap   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_carry <= '0;
        end else begin
            r_valid <= n_valid;
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;

endmodule

`default_nettype wire

// ===== rtl/tcp_receive_reassembly_tracker_unit.sv =====
// the token walks the cell row in a match pass, then an insert pass, into the result register
// and then the output register; a FIN segment goes straight to the output register
// a new segment is taken once the previous result sits in the output register
// reset: synchronous active low, clears all gaps, totals and the handshakes
// ----------------------------------------------------------------------------
// tcp_receive_reassembly_tracker_unit
// gap list tracker for tcp receive reassembly, gaps held in a chain of cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_receive_reassembly_tracker_unit
    import tcprr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_segment_sequence,
    input  wire logic [15:0] i_payload_bytes,
    input  wire logic        i_fin_flag,
    input  wire logic [15:0] i_peer_window,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_result_kind,
    output logic [31:0]      o_ack_number,
    output logic [15:0]      o_window_value,
    output logic [15:0]      o_write_offset,
    output logic [16:0]      o_write_count,
    output logic             o_hole_filled,
    output logic             o_hole_opened,
    output logic [16:0]      o_received_total,
    output logic             o_transfer_done,
    output logic             o_gap_overflow
);

    t_state      r_state, n_state;
    logic [16:0] r_buf_len;
    logic [31:0] r_init;
    logic [16:0] r_total;
    logic [31:0] r_highest;
    logic [31:0] r_rel;
    logic [15:0] r_size;
    logic [15:0] r_peer;
    logic        r_fin;
    logic        r_opened;
    t_carry      r_inject, n_inject;
    t_carry      r_res;
    logic        r_out_valid;

    t_carry w_carry [MAX_GAPS+1];
    t_bcast w_bcast;
    logic   w_in_fire;
    logic   w_capture;
    logic   w_last_act;

    logic signed [33:0] w_rel, w_end, w_len, w_tot;
    logic [33:0]        w_wcount;
    logic [15:0]        w_woff;
    logic [15:0]        w_win;
    logic [16:0]        w_new_total;
    logic [31:0]        w_new_highest;
    logic [15:0]        w_win_sat;
    logic [31:0]        w_ack;
    logic [31:0]        w_d;

    assign w_d   = i_segment_sequence - r_init;
    assign w_rel = {{2{r_rel[31]}}, r_rel};
    assign w_end = w_rel + $signed({18'd0, r_size});
    assign w_len = $signed({17'd0, r_buf_len});
    assign w_tot = $signed({17'd0, r_total});

    assign w_bcast.rel     = w_rel;
    assign w_bcast.seg_end = w_end;
    assign w_bcast.size_nz = (r_size != 16'd0);
    assign w_bcast.highest = r_highest;

    assign w_carry[0]  = r_inject;
    assign w_last_act  = w_carry[MAX_GAPS].active;

    for (genvar g = 0; g < MAX_GAPS; g++) begin : g_cell
        tcprr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bcast (w_bcast),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = i_fin_flag ? S_FINISH : S_WALK_A;
                end
            end
            S_WALK_A: begin
                if (w_last_act) begin
                    n_state = S_WALK_B;
                end
            end
            S_WALK_B: begin
                if (w_last_act) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_ready = 1'b0;
        w_capture  = 1'b0;
        case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_FINISH: w_capture  = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                w_capture  = 1'b0;
            end
        endcase
    end

    assign w_in_fire = i_in_valid && o_in_ready;

    // token injection
    always_comb begin
        n_inject        = w_carry[MAX_GAPS];
        n_inject.active = 1'b0;
        if (w_in_fire && !i_fin_flag) begin
            n_inject.active     = 1'b1;
            n_inject.phase      = PHASE_MATCH;
            n_inject.found      = 1'b0;
            n_inject.split_pend = 1'b0;
            n_inject.split_end  = 32'd0;
            n_inject.open_pend  = 1'b0;
            n_inject.any_gap    = 1'b0;
            n_inject.min_start  = 32'd0;
        end else if (r_state == S_WALK_A && w_last_act) begin
            n_inject.active    = 1'b1;
            n_inject.phase     = PHASE_INSERT;
            n_inject.open_pend = r_opened;
        end
    end

    // placement, total and window
    always_comb begin
        w_win_sat     = (r_peer >= r_size) ? (r_peer - r_size) : 16'd0;
        w_wcount      = 34'd0;
        w_woff        = 16'd0;
        w_win         = r_peer;
        w_new_total   = r_total;
        w_new_highest = r_highest;
        if (w_rel >= w_tot) begin
            if (w_end <= w_len) begin
                w_wcount = {18'd0, r_size};
                w_woff   = r_rel[15:0];
                if (w_end > w_tot) begin
                    w_new_total = w_end[16:0];
                    w_win       = w_win_sat;
                end
            end else begin
                if (w_rel < w_len) begin
                    w_wcount = w_len - w_rel;
                    w_woff   = r_rel[15:0];
                end
                w_new_total = r_buf_len;
            end
            if (w_end > $signed({2'b00, r_highest})) begin
                w_new_highest = w_end[31:0];
            end
        end else if (r_res.found) begin
            if (w_end <= w_len) begin
                w_wcount = {18'd0, r_size};
            end else if (w_rel < w_len) begin
                w_wcount = w_len - w_rel;
            end
            w_woff = r_rel[15:0];
            w_win  = w_win_sat;
        end
        if (w_wcount == 34'd0) begin
            w_woff = 16'd0;
        end
        w_ack = r_res.any_gap ? (r_res.min_start + r_init)
                              : (r_init + {15'd0, w_new_total});
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_rel    <= w_d;
            r_size   <= i_payload_bytes;
            r_peer   <= i_peer_window;
            r_fin    <= i_fin_flag;
            r_opened <= ($signed({{2{w_d[31]}}, w_d}) > $signed({2'b00, r_highest}));
        end
        if (r_state == S_WALK_B && w_last_act) begin
            r_res <= w_carry[MAX_GAPS];
        end
        if (w_capture) begin
            if (r_fin) begin
                o_result_kind    <= RESULT_FIN;
                o_ack_number     <= 32'd0;
                o_window_value   <= r_peer;
                o_write_offset   <= 16'd0;
                o_write_count    <= 17'd0;
                o_hole_filled    <= 1'b0;
                o_hole_opened    <= 1'b0;
                o_received_total <= r_total;
                o_transfer_done  <= 1'b1;
                o_gap_overflow   <= 1'b0;
            end else begin
                o_result_kind    <= RESULT_ACK;
                o_ack_number     <= w_ack;
                o_window_value   <= w_win;
                o_write_offset   <= w_woff;
                o_write_count    <= w_wcount[16:0];
                o_hole_filled    <= r_res.found;
                o_hole_opened    <= r_opened;
                o_received_total <= w_new_total;
                o_transfer_done  <= (w_new_total >= r_buf_len) && !r_res.any_gap;
                o_gap_overflow   <= r_res.split_pend || r_res.open_pend;
            end
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= '0;
            r_buf_len   <= BUF_LEN_RESET;
            r_init      <= 32'd0;
            r_total     <= 17'd0;
            r_highest   <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= n_inject;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BUFFER_LENGTH:    r_buf_len <= i_cfg_data[16:0];
                    CFG_INITIAL_SEQUENCE: r_init    <= i_cfg_data;
                    default:              r_init    <= r_init;
                endcase
            end
            if (w_capture && !r_fin) begin
                r_total   <= w_new_total;
                r_highest <= w_new_highest;
            end
            if (w_capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/tcprr_checker.sv =====
// ----------------------------------------------------------------------------
// tcprr_checker
// port level checks of the tcp receive reassembly tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_receive_reassembly_tracker_unit_assert.svh"

module tcprr_checker
    import tcprr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_result_kind,
    input wire logic [31:0] o_ack_number,
    input wire logic [15:0] o_write_offset,
    input wire logic [16:0] o_write_count,
    input wire logic        o_transfer_done
);

    // one segment at a time
    `TCPRR_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // fin result carries no ack and no placement
    `TCPRR_ASSERT_IMPL(a_fin_result, i_clk, i_rst_n, o_out_valid && o_result_kind == RESULT_FIN, o_transfer_done && o_ack_number == 32'd0 && o_write_count == 17'd0)

    // nothing stored means offset zero
    `TCPRR_ASSERT_IMPL(a_offset_zero, i_clk, i_rst_n, o_out_valid && o_write_count == 17'd0, o_write_offset == 16'd0)

    // stalled result holds
    `TCPRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_ack_number))

endmodule

bind tcp_receive_reassembly_tracker_unit tcprr_checker u_tcprr_checker (.*);

`default_nettype wire
